/* hw/rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and codes for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int unsigned MAX_BLOCKS_DEF   = 64;
   localparam int unsigned HEADER_BYTES_DEF = 32;

   localparam logic [31:0] ALIGN_MASK = 32'h0000_0007;
   localparam logic [31:0] MAX_REQ    = 32'hFFFF_FFF8;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   typedef logic [2:0] status_type;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_NULL     = 3'd1;
   localparam status_type ST_NOMEM    = 3'd2;
   localparam status_type ST_FULL     = 3'd3;
   localparam status_type ST_OUTSIDE  = 3'd4;
   localparam status_type ST_NOTBLOCK = 3'd5;
   localparam status_type ST_DOUBLE   = 3'd6;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] size;
      logic        free;
   } entry_type;

endpackage

/* hw/rtl/ffba_table.sv */
// ----------------------------------------------------------------------------
// ffba_table
// Block table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ffba_table #(
   parameter int unsigned DEPTH = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned IDX_W = 6
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output ffba_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  ffba_pkg::entry_type wr_data
);

   ffba_pkg::entry_type mem [DEPTH];
   ffba_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/first_fit_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap allocator over a bump-pointer region with a block table.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_opcode, req_request_size and req_release_address with
//   start high; the word is taken at a clock edge where busy is low. busy
//   then stays high until the result is produced.
//   Result: rsp_valid is high for exactly one cycle with rsp_payload_address
//   and rsp_status. The receiver cannot stall; the word must be taken then.
//   A new request may be accepted in the same cycle the result is shown.
//   Config: csr_valid/csr_ready write heap_base (index 0) or heap_limit
//   (index 1). csr_ready is always high; write only while the block is idle.
// Timing:
//   One table entry is examined per cycle through a single read port and a
//   single shared subtract/compare unit, up to block_count entries per scan.
//   Early rejects answer from S_PRE; a release, or an allocate that reuses a
//   free block, answers from S_SCAN; an append passes S_SCAN, S_NEED and
//   S_APPEND before it answers. busy falls as the strobe rises.
// Reset:
//   Synchronous reset clears the state, the heap base and limit, the break,
//   the block count and the result strobe. The table itself is not cleared;
//   entries at or above the block count are never read.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core #(
   parameter int unsigned MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_release_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_payload_address,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [31:0] HDR = 32'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PRE    = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_NEED   = 3'd3;
   localparam logic [2:0] S_APPEND = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic                  op_ff, op_in;
   logic [31:0]           size_ff, size_in;
   logic [31:0]           addr_ff, addr_in;
   logic [31:0]           key_ff, key_in;
   logic [32:0]           need_ff, need_in;
   logic [CNT_W-1:0]      iss_ff, iss_in;
   logic                  pv_ff, pv_in;
   logic [IDX_W-1:0]      pidx_ff, pidx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [31:0]           brk_ff, brk_in;
   logic                  started_ff, started_in;
   logic [31:0]           base_ff, base_in;
   logic [31:0]           limit_ff, limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_addr_ff, rsp_addr_in;
   ffba_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic [31:0]           cur_brk;
   logic [31:0]           rel_start;
   logic [31:0]           rounded;
   logic [33:0]           next_brk;
   logic                  rd_en;
   ffba_pkg::entry_type   rd_data;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   ffba_pkg::entry_type   wr_data;
   logic [31:0]           cmp_a;
   logic [32:0]           cmp_diff;
   logic                  cmp_ge;
   logic                  cmp_eq;
   logic                  hit;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign cur_brk   = started_ff ? brk_ff : base_ff;
   assign rel_start = addr_ff - HDR;
   assign rounded   = (size_ff + ffba_pkg::ALIGN_MASK) & ~ffba_pkg::ALIGN_MASK;
   assign next_brk  = {2'b00, cur_brk} + {1'b0, need_ff};

   assign rd_en = (state_ff == S_SCAN) && (iss_ff < count_ff);

   // shared compare: size >= key on allocate, base == key on release
   assign cmp_a    = (op_ff == ffba_pkg::OP_ALLOC) ? rd_data.size : rd_data.base;
   assign cmp_diff = {1'b0, cmp_a} - {1'b0, key_ff};
   assign cmp_ge   = !cmp_diff[32];
   assign cmp_eq   = (cmp_diff == 33'd0);
   assign hit      = pv_ff && ((op_ff == ffba_pkg::OP_ALLOC) ? (rd_data.free && cmp_ge)
                                                              : cmp_eq);

   ffba_table #(
      .DEPTH (MAX_BLOCKS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = accept ? req_opcode : op_ff;
      size_in       = accept ? req_request_size : size_ff;
      addr_in       = accept ? req_release_address : addr_ff;
      key_in        = key_ff;
      need_in       = need_ff;
      iss_in        = rd_en ? (iss_ff + CNT_W'(1)) : iss_ff;
      pv_in         = rd_en;
      pidx_in       = iss_ff[IDX_W-1:0];
      count_in      = count_ff;
      brk_in        = brk_ff;
      started_in    = started_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = pidx_ff;
      wr_data       = rd_data;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ffba_pkg::REG_HEAP_BASE:  base_in  = csr_data;
            ffba_pkg::REG_HEAP_LIMIT: limit_in = csr_data;
            default:                  base_in  = base_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            iss_in      = '0;
            rsp_addr_in = 32'd0;
            state_in    = S_SCAN;
            if (op_ff == ffba_pkg::OP_ALLOC) begin
               key_in = rounded;
               if (size_ff == 32'd0) begin
                  rsp_status_in = ffba_pkg::ST_NULL;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else if (size_ff > ffba_pkg::MAX_REQ) begin
                  rsp_status_in = ffba_pkg::ST_NOMEM;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               key_in = rel_start;
               if (addr_ff == 32'd0) begin
                  rsp_status_in = ffba_pkg::ST_NULL;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else if (addr_ff < HDR || rel_start < base_ff || rel_start >= cur_brk) begin
                  rsp_status_in = ffba_pkg::ST_OUTSIDE;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (op_ff == ffba_pkg::OP_ALLOC) begin
                  wr_en         = 1'b1;
                  wr_data.free  = 1'b0;
                  rsp_addr_in   = rd_data.base + HDR;
                  rsp_status_in = ffba_pkg::ST_OK;
               end else if (rd_data.free) begin
                  rsp_status_in = ffba_pkg::ST_DOUBLE;
               end else begin
                  wr_en         = 1'b1;
                  wr_data.free  = 1'b1;
                  rsp_status_in = ffba_pkg::ST_OK;
               end
            end else if (!pv_ff && !rd_en) begin
               if (op_ff == ffba_pkg::OP_ALLOC) begin
                  state_in = S_NEED;
               end else begin
                  rsp_status_in = ffba_pkg::ST_NOTBLOCK;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_NEED: begin
            need_in  = {1'b0, HDR} + {1'b0, key_ff};
            state_in = S_APPEND;
         end
         S_APPEND: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (next_brk[33:32] != 2'b00) begin
               rsp_status_in = ffba_pkg::ST_NOMEM;
            end else if (next_brk[31:0] < base_ff || next_brk[31:0] >= limit_ff) begin
               rsp_status_in = ffba_pkg::ST_NOMEM;
            end else if (count_ff >= CNT_MAX) begin
               rsp_status_in = ffba_pkg::ST_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[IDX_W-1:0];
               wr_data.base  = cur_brk;
               wr_data.size  = key_ff;
               wr_data.free  = 1'b0;
               count_in      = count_ff + CNT_W'(1);
               brk_in        = next_brk[31:0];
               started_in    = 1'b1;
               rsp_addr_in   = cur_brk + HDR;
               rsp_status_in = ffba_pkg::ST_OK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iss_ff       <= '0;
         pv_ff        <= 1'b0;
         count_ff     <= '0;
         brk_ff       <= 32'd0;
         started_ff   <= 1'b0;
         base_ff      <= 32'd0;
         limit_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         pv_ff        <= pv_in;
         count_ff     <= count_in;
         brk_ff       <= brk_in;
         started_ff   <= started_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      key_ff        <= key_in;
      need_ff       <= need_in;
      pidx_ff       <= pidx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_payload_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

/* hw/rtl/ffba_checker.sv */
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks for the first-fit block allocator, bound to the top.
// ----------------------------------------------------------------------------
module ffba_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_payload_address,
   input logic [2:0]  rsp_status
);

   // an accepted word raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // result words never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // every busy period ends with a result
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ffba_pkg::ST_OK) |-> (rsp_payload_address == 32'd0))
      else $error("nonzero address on failed request");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (.*);

/* dv/ffba_alloc_checker.sv */
// ----------------------------------------------------------------------------
// ffba_alloc_checker
// Watches the request, result and register channels of the allocator, keeps
// its own copy of the heap break and block table, predicts every result word
// and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module ffba_alloc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_request_size,
   input  logic [31:0] req_release_address,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_payload_address,
   input  logic [2:0]  rsp_status,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          outstanding
);

   localparam int unsigned NBLK = ffba_pkg::MAX_BLOCKS_DEF;
   localparam logic [31:0] HDR  = 32'(ffba_pkg::HEADER_BYTES_DEF);

   typedef struct packed {
      logic [31:0]          addr;
      ffba_pkg::status_type status;
   } alloc_outcome_type;

   alloc_outcome_type expected_outcomes[$];

   logic [31:0] cfg_base;
   logic [31:0] cfg_limit;
   logic [31:0] brk_ptr;
   logic        heap_live;
   int unsigned num_blocks;
   logic [31:0] tbl_base [NBLK];
   logic [31:0] tbl_size [NBLK];
   logic        tbl_free [NBLK];

   task automatic predict_alloc(input logic [31:0] req_size, output alloc_outcome_type res);
      logic [31:0] rounded;
      logic [31:0] old_brk;
      logic [32:0] need;
      logic [33:0] next_brk;
      bit          reused;
      int          i;
      reused     = 1'b0;
      res.addr   = '0;
      res.status = ffba_pkg::ST_OK;
      if (req_size == 32'd0) begin
         res.status = ffba_pkg::ST_NULL;
      end else if (req_size > ffba_pkg::MAX_REQ) begin
         res.status = ffba_pkg::ST_NOMEM;
      end else begin
         rounded = (req_size + ffba_pkg::ALIGN_MASK) & ~ffba_pkg::ALIGN_MASK;
         // first fit in creation order, no split
         for (i = 0; i < num_blocks; i++) begin
            if (!reused && tbl_free[i] && tbl_size[i] >= rounded) begin
               reused     = 1'b1;
               tbl_free[i] = 1'b0;
               res.addr   = tbl_base[i] + HDR;
            end
         end
         if (!reused) begin
            old_brk  = heap_live ? brk_ptr : cfg_base;
            need     = {1'b0, HDR} + {1'b0, rounded};
            next_brk = {2'b00, old_brk} + {1'b0, need};
            if (need[32] || next_brk[33:32] != 2'b00) begin
               res.status = ffba_pkg::ST_NOMEM;
            end else if (next_brk[31:0] < cfg_base || next_brk[31:0] >= cfg_limit) begin
               res.status = ffba_pkg::ST_NOMEM;
            end else if (num_blocks >= NBLK) begin
               res.status = ffba_pkg::ST_FULL;
            end else begin
               heap_live              = 1'b1;
               brk_ptr                = next_brk[31:0];
               tbl_base[num_blocks]   = old_brk;
               tbl_size[num_blocks]   = rounded;
               tbl_free[num_blocks]   = 1'b0;
               num_blocks++;
               res.addr               = old_brk + HDR;
            end
         end
      end
   endtask

   task automatic predict_release(input logic [31:0] pay, output alloc_outcome_type res);
      logic [31:0] blk_start;
      bit          matched;
      int          i;
      matched  = 1'b0;
      res.addr = '0;
      if (pay == 32'd0) begin
         res.status = ffba_pkg::ST_NULL;
      end else if (pay < HDR) begin
         res.status = ffba_pkg::ST_OUTSIDE;
      end else begin
         blk_start = pay - HDR;
         if (blk_start < cfg_base || blk_start >= (heap_live ? brk_ptr : cfg_base)) begin
            res.status = ffba_pkg::ST_OUTSIDE;
         end else begin
            res.status = ffba_pkg::ST_NOTBLOCK;
            for (i = 0; i < num_blocks; i++) begin
               if (!matched && tbl_base[i] == blk_start) begin
                  matched = 1'b1;
                  if (tbl_free[i]) begin
                     res.status = ffba_pkg::ST_DOUBLE;
                  end else begin
                     tbl_free[i] = 1'b1;
                     res.status  = ffba_pkg::ST_OK;
                  end
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      alloc_outcome_type want;
      alloc_outcome_type next_res;
      if (reset) begin
         cfg_base    = '0;
         cfg_limit   = '0;
         brk_ptr     = '0;
         heap_live   = 1'b0;
         num_blocks  = 0;
         error_count = 0;
         expected_outcomes.delete();
      end else begin
         // result of the previous word first; a new word may be taken this edge
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: result word with nothing expected: addr %h status %0d",
                        $time, rsp_payload_address, rsp_status);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_payload_address !== want.addr) begin
                  error_count++;
                  $display("%0t: payload address mismatch: expected %h, got %h",
                           $time, want.addr, rsp_payload_address);
               end
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, want.status, rsp_status);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == ffba_pkg::REG_HEAP_BASE) cfg_base = csr_data;
            else cfg_limit = csr_data;
         end
         if (start && !busy) begin
            if (req_opcode == ffba_pkg::OP_ALLOC) predict_alloc(req_request_size, next_res);
            else predict_release(req_release_address, next_res);
            expected_outcomes.push_back(next_res);
         end
      end
      outstanding = expected_outcomes.size();
   end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the first-fit block allocator: directed corner words over
// several heap settings, then random allocate/release traffic with random
// gaps, re-programming base and limit between phases. Checking is done in
// ffba_alloc_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int NBLK        = ffba_pkg::MAX_BLOCKS_DEF;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [31:0] req_request_size;
   logic [31:0] req_release_address;
   logic        rsp_valid;
   logic [31:0] rsp_payload_address;
   logic [2:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   int          checker_errors;
   int          results_owed;
   int          cycle_count;
   int          burst_left;
   logic [31:0] cur_base;
   logic [31:0] granted[$];

   first_fit_block_allocator_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_request_size    (req_request_size),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   ffba_alloc_checker checker_i (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_request_size    (req_request_size),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_payload_address (rsp_payload_address),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .error_count         (checker_errors),
      .outstanding         (results_owed)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // payload addresses handed out, reused as release targets
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_status == ffba_pkg::ST_OK &&
          rsp_payload_address != 32'd0) begin
         granted.push_back(rsp_payload_address);
         if (granted.size() > 128) granted.delete(0);
      end
   end

   task automatic drain();
      start = 1'b0;
      while (results_owed != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [31:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      @(negedge clock);
   endtask

   task automatic set_heap(input logic [31:0] base, input logic [31:0] limit);
      drain();
      write_reg(ffba_pkg::REG_HEAP_BASE, base);
      write_reg(ffba_pkg::REG_HEAP_LIMIT, limit);
      cur_base = base;
   endtask

   task automatic issue(input logic op, input logic [31:0] size, input logic [31:0] addr);
      int gap;
      int pick;
      start               = 1'b1;
      req_opcode          = op;
      req_request_size    = size;
      req_release_address = addr;
      do @(posedge clock); while (busy);
      @(negedge clock);
      pick = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else if (pick < 3) begin
         burst_left = $urandom_range(10, 40);
         gap = 0;
      end else if (pick < 40) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      if ($urandom_range(0, 149) == 0) drain();
   endtask

   task automatic run_phase(input logic [31:0] base, input logic [31:0] limit, input int words);
      logic [31:0] size;
      logic [31:0] addr;
      int          pick;
      set_heap(base, limit);
      for (int n = 0; n < words; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) size = $urandom_range(1, 256);
         else if (pick < 80) size = $urandom_range(257, 4096);
         else if (pick < 85) size = 32'd0;
         else if (pick < 95) size = $urandom;
         else size = 32'hFFFF_FFF0 + $urandom_range(0, 15);
         pick = $urandom_range(0, 99);
         if (pick < 60 && granted.size() != 0)
            addr = granted[$urandom_range(0, granted.size() - 1)];
         else if (pick < 70 && granted.size() != 0)
            addr = granted[$urandom_range(0, granted.size() - 1)] + $urandom_range(1, 40);
         else if (pick < 75) addr = 32'd0;
         else if (pick < 80) addr = $urandom_range(1, 31);
         else if (pick < 90) addr = $urandom;
         else addr = cur_base + $urandom_range(0, 32'h2000);
         if ($urandom_range(0, 99) < 55) issue(ffba_pkg::OP_ALLOC, size, $urandom);
         else issue(ffba_pkg::OP_RELEASE, $urandom, addr);
      end
   endtask

   initial begin : stimulus
      logic [31:0] b;
      reset               = 1'b1;
      start               = 1'b0;
      req_opcode          = ffba_pkg::OP_ALLOC;
      req_request_size    = '0;
      req_release_address = '0;
      csr_valid           = 1'b0;
      csr_index           = ffba_pkg::REG_HEAP_BASE;
      csr_data            = '0;
      cycle_count         = 0;
      burst_left          = 0;
      cur_base            = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset values: zero base and limit, every append is out of memory
      issue(ffba_pkg::OP_ALLOC, 32'd0, $urandom);
      issue(ffba_pkg::OP_ALLOC, 32'd1, $urandom);
      issue(ffba_pkg::OP_ALLOC, 32'hFFFF_FFFF, $urandom);
      issue(ffba_pkg::OP_ALLOC, 32'hFFFF_FFF8, $urandom);
      issue(ffba_pkg::OP_RELEASE, $urandom, 32'd0);
      issue(ffba_pkg::OP_RELEASE, $urandom, 32'd31);
      issue(ffba_pkg::OP_RELEASE, $urandom, 32'hFFFF_FFFF);

      // heap at the top of the address space: new break wraps
      set_heap(32'hFFFF_FFC0, 32'hFFFF_FFFF);
      issue(ffba_pkg::OP_ALLOC, 32'd32, $urandom);
      issue(ffba_pkg::OP_RELEASE, $urandom, 32'hFFFF_FFF0);

      // heap starts here; blocks of 8, 8 and 16 bytes
      b = $urandom_range(32'h100, 32'hFF_FFFF);
      set_heap(b, b + 32'h1000);
      issue(ffba_pkg::OP_ALLOC, 32'd1, $urandom);
      issue(ffba_pkg::OP_ALLOC, 32'd8, $urandom);
      issue(ffba_pkg::OP_ALLOC, 32'd9, $urandom);
      issue(ffba_pkg::OP_RELEASE, $urandom, b + 32'd72);
      issue(ffba_pkg::OP_RELEASE, $urandom, b + 32'd72);
      issue(ffba_pkg::OP_RELEASE, $urandom, b + 32'd80);
      issue(ffba_pkg::OP_RELEASE, $urandom, b + 32'd31);
      issue(ffba_pkg::OP_RELEASE, $urandom, b + 32'd160);
      issue(ffba_pkg::OP_ALLOC, 32'd5, $urandom);
      issue(ffba_pkg::OP_ALLOC, 32'h1000, $urandom);
      issue(ffba_pkg::OP_RELEASE, $urandom, b + 32'd112);
      issue(ffba_pkg::OP_ALLOC, 32'd1, $urandom);

      run_phase(b, b + 32'h1000, 150);
      run_phase(b, 32'hFFFF_FFFF, 500);
      run_phase(b, 32'd0, 200);
      run_phase(32'd0, 32'hFFFF_FFFF, 300);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
      run_phase(b, $urandom, 500);

      drain();
      repeat (NBLK + 8) @(negedge clock);
      if (checker_errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_table.sv
hw/rtl/first_fit_block_allocator_core.sv
hw/rtl/ffba_checker.sv
dv/ffba_alloc_checker.sv
dv/tb_top.sv
